### hw/rtl/sactc_pkg.sv
// Shared types, constants and defaults for the set-associative cache tag controller.
package sactc_pkg;

  // Default geometry handed to the top level.
  localparam int DEF_SETS     = 64;
  localparam int DEF_WAYS     = 4;
  localparam int DEF_TAG_BITS = 32;

  // Fixed field widths of the access and result items.
  localparam int CMD_W       = 1;
  localparam int SET_IDX_W   = 6;
  localparam int TAG_IN_W    = 32;
  localparam int CYCLES_W    = 11;
  localparam int WAY_OUT_W   = 2;
  localparam int PENALTY_W   = 10;
  localparam int SEED_W      = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic                 RST_REPLACE_FIFO = 1'b0;
  localparam logic                 RST_WRITE_BACK   = 1'b0;
  localparam logic [PENALTY_W-1:0] RST_MISS_PENALTY = 10'd100;
  localparam logic [SEED_W-1:0]    RST_RANDOM_SEED  = 16'd1;

  // Galois LFSR feedback taps.
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  // Access kinds.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLACE_FIFO = 2'd0,
    CFG_WRITE_BACK   = 2'd1,
    CFG_MISS_PENALTY = 2'd2,
    CFG_RANDOM_SEED  = 2'd3
  } cfg_reg_t;

  // Controller sequencing.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

endpackage

### hw/rtl/set_assoc_cache_tag_controller_unit.sv
// A result is registered when the lookup after its access transfer ends; a full result register stalls it.
// The state memory read is followed by compare and write-back; the next access waits for both to end.
// A new access transfer is taken while an earlier result still waits on the output register.
// Reset is synchronous and active low; it loads the register defaults and the LFSR seed,
// then a clearing pass through every set invalidates every line before the first access.
// Configuration writes are taken in every cycle, the clearing pass included.
module set_assoc_cache_tag_controller_unit
  import sactc_pkg::*;
#(
  parameter int SETS     = DEF_SETS,
  parameter int WAYS     = DEF_WAYS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Access channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0 up: command[0], set_index[6:1], tag[38:7], zero pad[39].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata from bit 0 up: hit[0], cycles[11:1], writeback[12], way[14:13], zero pad[15].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W  = WAY_W;
  localparam int AGE1_W = AGE_W + 1;
  // Each state row holds the valid bits, the dirty bits and the FIFO ages of one set.
  localparam int ROW_W  = WAYS * (2 + AGE_W);
  localparam int TROW_W = WAYS * TAG_BITS;
  localparam int IDX_SPAN = 2 ** SET_IDX_W;
  localparam int BYTE_MOD = 256 % WAYS;

  // Configuration registers.
  logic                 fifo_mode_r;
  logic                 wb_mode_r;
  logic [PENALTY_W-1:0] penalty_r;
  logic [SEED_W-1:0]    lfsr_r;
  logic [SEED_W-1:0]    lfsr_nxt;

  // Sequencing.
  ctrl_state_t      state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r;
  logic             clr_we;
  logic             upd_en;
  logic             in_xfer;

  // Access held during lookup.
  logic                cmd_r;
  logic [SET_W-1:0]    set_r;
  logic [TAG_BITS-1:0] tag_r;

  // Memories and their registered read data.
  logic [ROW_W-1:0]  st_mem [SETS];
  logic [TROW_W-1:0] tag_mem [SETS];
  logic [ROW_W-1:0]  st_rdata_r;
  logic [TROW_W-1:0] tag_rdata_r;
  logic [ROW_W-1:0]  st_wdata;
  logic [TROW_W-1:0] tag_wdata;
  logic [SET_W-1:0]  st_waddr;
  logic              st_we;

  // Index folding and random victim tables.
  logic [SET_W-1:0] set_lut [IDX_SPAN];
  logic [WAY_W-1:0] mod_lut [256];
  logic [SET_W-1:0] in_set;

  // Result register.
  logic                out_valid_r;
  logic                out_hit_r;
  logic [CYCLES_W-1:0] out_cycles_r;
  logic                out_wb_r;
  logic [WAY_W-1:0]    out_way_r;

  // Lookup and replacement logic.
  logic [WAYS-1:0]     cur_v, cur_d, new_v, new_d;
  logic [AGE_W-1:0]    cur_a [WAYS];
  logic [AGE_W-1:0]    new_a [WAYS];
  logic [TAG_BITS-1:0] cur_t [WAYS];
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic                alloc;
  logic                free_found;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    old_way;
  logic [WAY_W-1:0]    rnd_way;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    res_way;
  logic                wb_flag;
  logic [CYCLES_W-1:0] res_cycles;
  logic [AGE1_W-1:0]   age_inc;
  logic [SEED_W-1:0]   lfsr_step;
  logic [WAY_W-1:0]    m_hi, m_lo;
  logic [7:0]          mod_sum;

  // A set index beyond the set count folds back modulo SETS.
  for (genvar g = 0; g < IDX_SPAN; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % SETS);
  end

  for (genvar g = 0; g < 256; g++) begin : g_mod_lut
    assign mod_lut[g] = WAY_W'(g % WAYS);
  end

  assign in_set  = set_lut[in_tdata[SET_IDX_W:1]];
  assign in_xfer = in_tvalid && in_tready;

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Controller: clear every state row, then handle one access at a time.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SET_W'(SETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (upd_en) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // The lookup finishes only when the result register is free or being drained.
  always_comb begin
    in_tready = 1'b0;
    clr_we    = 1'b0;
    upd_en    = 1'b0;
    case (state_r)
      ST_CLEAR:  clr_we    = 1'b1;
      ST_IDLE:   in_tready = 1'b1;
      ST_LOOKUP: upd_en    = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  // Access capture.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_tdata[0];
      set_r <= in_set;
      tag_r <= in_tdata[7 +: TAG_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: read at the access transfer, written back when the lookup ends, state rows also cleared.
  // ---------------------------------------------------------------------------
  assign st_we    = clr_we || upd_en;
  assign st_waddr = clr_we ? clr_cnt_r : set_r;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= clr_we ? '0 : st_wdata;
    if (in_xfer) st_rdata_r <= st_mem[in_set];
  end

  always_ff @(posedge clk) begin
    if (upd_en) tag_mem[set_r] <= tag_wdata;
    if (in_xfer) tag_rdata_r <= tag_mem[in_set];
  end

  // ---------------------------------------------------------------------------
  // Random victim: step the LFSR once, then take the new value modulo WAYS
  // by folding its two bytes through the residue table.
  // ---------------------------------------------------------------------------
  always_comb begin
    lfsr_step = {1'b0, lfsr_r[SEED_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
    m_hi      = mod_lut[lfsr_step[15:8]];
    m_lo      = mod_lut[lfsr_step[7:0]];
    mod_sum   = 8'(32'(m_hi) * BYTE_MOD + 32'(m_lo));
    rnd_way   = mod_lut[mod_sum];
  end

  // ---------------------------------------------------------------------------
  // Compare, age, choose a victim and build the rows to write back.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      cur_v[w] = st_rdata_r[w];
      cur_d[w] = st_rdata_r[WAYS + w];
      cur_a[w] = st_rdata_r[2 * WAYS + w * AGE_W +: AGE_W];
      cur_t[w] = tag_rdata_r[w * TAG_BITS +: TAG_BITS];
    end

    // The lowest matching valid way wins.
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && cur_v[w] && (cur_t[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end

    // A store miss in write-through mode leaves the set untouched.
    alloc = !hit && ((cmd_r == CMD_LOAD) || wb_mode_r);

    // FIFO aging on an allocation: every valid way gets older, and one that reaches WAYS is evicted.
    new_v   = cur_v;
    new_d   = cur_d;
    new_a   = cur_a;
    wb_flag = 1'b0;
    age_inc = '0;
    if (alloc && fifo_mode_r) begin
      for (int w = 0; w < WAYS; w++) begin
        age_inc = {1'b0, cur_a[w]} + AGE1_W'(1);
        if (cur_v[w]) begin
          if (age_inc >= AGE1_W'(WAYS)) begin
            new_a[w] = '0;
            new_v[w] = 1'b0;
            new_d[w] = 1'b0;
            wb_flag  = wb_flag | cur_d[w];
          end else begin
            new_a[w] = age_inc[AGE_W-1:0];
          end
        end
      end
    end

    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!free_found && !new_v[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end

    // Oldest way, lowest index on a tie; only used when the set is still full.
    old_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (new_a[w] > new_a[old_way]) old_way = WAY_W'(w);
    end

    if (free_found) begin
      victim = free_way;
    end else if (fifo_mode_r) begin
      victim = old_way;
    end else begin
      victim = rnd_way;
    end

    tag_wdata = tag_rdata_r;
    if (alloc) begin
      if (!free_found) wb_flag = wb_flag | new_d[victim];
      new_v[victim] = 1'b1;
      new_d[victim] = (cmd_r == CMD_STORE);
      new_a[victim] = '0;
      tag_wdata[victim * TAG_BITS +: TAG_BITS] = tag_r;
    end else if (hit && (cmd_r == CMD_STORE) && wb_mode_r) begin
      new_d[hit_way] = 1'b1;
    end

    st_wdata = '0;
    for (int w = 0; w < WAYS; w++) begin
      st_wdata[w]                                = new_v[w];
      st_wdata[WAYS + w]                         = new_d[w];
      st_wdata[2 * WAYS + w * AGE_W +: AGE_W]    = new_a[w];
    end

    if (hit) begin
      res_way = hit_way;
    end else if (alloc) begin
      res_way = victim;
    end else begin
      res_way = '0;
    end
    res_cycles = alloc ? (CYCLES_W'(1) + CYCLES_W'(penalty_r)) : CYCLES_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Configuration registers and LFSR. The LFSR steps only when a random
  // replacement finds the set full; a seed write reloads it, zero loading as one.
  // ---------------------------------------------------------------------------
  always_comb begin
    lfsr_nxt = lfsr_r;
    if (cfg_valid && cfg_ready && (cfg_index == CFG_RANDOM_SEED)) begin
      lfsr_nxt = (cfg_data == '0) ? SEED_W'(1) : cfg_data;
    end else if (upd_en && alloc && !free_found && !fifo_mode_r) begin
      lfsr_nxt = lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_mode_r <= RST_REPLACE_FIFO;
      wb_mode_r   <= RST_WRITE_BACK;
      penalty_r   <= RST_MISS_PENALTY;
      lfsr_r      <= RST_RANDOM_SEED;
    end else begin
      lfsr_r <= lfsr_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REPLACE_FIFO: fifo_mode_r <= cfg_data[0];
          CFG_WRITE_BACK:   wb_mode_r   <= cfg_data[0];
          CFG_MISS_PENALTY: penalty_r   <= cfg_data[PENALTY_W-1:0];
          default: begin
            fifo_mode_r <= fifo_mode_r;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: loaded when a lookup ends, cleared when its transfer completes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_hit_r    <= hit;
      out_cycles_r <= res_cycles;
      out_wb_r     <= wb_flag;
      out_way_r    <= res_way;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, WAY_OUT_W'(out_way_r), out_wb_r, out_cycles_r, out_hit_r};

endmodule
